/* hdl/ffba_pkg.sv */
// shared types and constants of the first-fit block allocator
// used by ffba_ctrl and first_fit_block_allocator; no dependencies
package ffba_pkg;

    // table size and header length
    localparam int unsigned MAX_BLOCKS   = 64;
    localparam int unsigned HEADER_BYTES = 16;
    localparam int unsigned IDX_W        = $clog2(MAX_BLOCKS);
    localparam int unsigned CNT_W        = $clog2(MAX_BLOCKS + 1);

    // field widths
    localparam int unsigned ADDR_W   = 32;
    localparam int unsigned SIZE_W   = 24;
    localparam int unsigned STATUS_W = 3;
    localparam int unsigned CFG_IDX_W = 1;

    // request kinds
    localparam logic KIND_ALLOC   = 1'b0;
    localparam logic KIND_RELEASE = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_REUSED   = 3'd0;
    localparam logic [STATUS_W-1:0] ST_NEW      = 3'd1;
    localparam logic [STATUS_W-1:0] ST_RELEASED = 3'd2;
    localparam logic [STATUS_W-1:0] ST_REFUSED  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_BADADDR  = 3'd4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_HEAP_BASE  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEAP_LIMIT = 1'd1;

    // one table entry as stored in memory
    typedef struct packed {
        logic [ADDR_W-1:0] start;
        logic [SIZE_W-1:0] size;
        logic              free;
    } t_entry;

    localparam int unsigned ENTRY_W = $bits(t_entry);

    // result handed from the controller to the output register
    typedef struct packed {
        logic                vld;
        logic [ADDR_W-1:0]   addr;
        logic [STATUS_W-1:0] status;
    } t_result;

    // controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

endpackage

/* hdl/ffba_ram.sv */
// generic single-write, single-read memory with registered read data
// no dependencies
module ffba_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* hdl/ffba_ctrl.sv */
// allocator sequencer: table walk over the entry memory, then commit of one item
// depends on ffba_pkg and ffba_ram
module ffba_ctrl (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic                            i_kind,
    input  logic [ffba_pkg::SIZE_W-1:0]     i_request_size,
    input  logic [ffba_pkg::ADDR_W-1:0]     i_block_address,
    input  logic [ffba_pkg::ADDR_W-1:0]     i_heap_base,
    input  logic [ffba_pkg::ADDR_W-1:0]     i_heap_limit,
    input  logic                            i_out_ready,
    output ffba_pkg::t_result               o_res
);
    import ffba_pkg::*;

    localparam logic [ADDR_W-1:0] HDR = ADDR_W'(HEADER_BYTES);

    t_state             r_state, n_state;
    logic               r_kind;
    logic [SIZE_W-1:0]  r_req;
    logic [ADDR_W-1:0]  r_addr_off;
    logic               r_zero;
    logic [CNT_W-1:0]   r_rd_idx, n_rd_idx;
    logic               r_chk_vld, n_chk_vld;
    logic [IDX_W-1:0]   r_chk_idx, n_chk_idx;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [ADDR_W-1:0]  r_break, n_break;
    logic               r_hit, n_hit;
    logic [IDX_W-1:0]   r_hit_idx, n_hit_idx;
    t_entry             r_hit_ent, n_hit_ent;

    logic               accept;
    logic               rd_en;
    logic               we;
    logic [IDX_W-1:0]   waddr;
    t_entry             wdata;
    logic [ENTRY_W-1:0] rdata;
    t_entry             ent;
    logic               match;
    logic [ADDR_W:0]    new_end;
    logic               fits;

    ffba_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(MAX_BLOCKS)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_re   (rd_en),
        .i_raddr(r_rd_idx[IDX_W-1:0]),
        .o_rdata(rdata)
    );

    assign accept     = (r_state == S_IDLE) && i_in_valid;
    assign o_in_stall = (r_state != S_IDLE);

    // entry check for the read issued last cycle
    assign ent   = t_entry'(rdata);
    assign match = r_chk_vld &&
                   ((r_kind == KIND_ALLOC) ? (ent.free && (ent.size >= r_req))
                                           : (ent.start == r_addr_off));

    // room check for a block appended at the break, without wrap
    assign new_end = {1'b0, r_break} + (ADDR_W + 1)'(HEADER_BYTES) + (ADDR_W + 1)'(r_req);
    assign fits    = (r_count < CNT_W'(MAX_BLOCKS)) && (new_end <= {1'b0, i_heap_limit});

    // item registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_kind     <= i_kind;
            r_req      <= i_request_size;
            r_addr_off <= i_block_address - i_heap_base - HDR;
            r_zero     <= (i_kind == KIND_ALLOC) && (i_request_size == '0);
        end
        r_rd_idx  <= n_rd_idx;
        r_chk_idx <= n_chk_idx;
        r_hit     <= n_hit;
        r_hit_idx <= n_hit_idx;
        r_hit_ent <= n_hit_ent;
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_chk_vld <= 1'b0;
            r_count   <= '0;
            r_break   <= '0;
        end else begin
            r_state   <= n_state;
            r_chk_vld <= n_chk_vld;
            r_count   <= n_count;
            r_break   <= n_break;
        end
    end

    // next state, table walk and commit
    always_comb begin
        n_state   = r_state;
        n_rd_idx  = r_rd_idx;
        n_chk_vld = 1'b0;
        n_chk_idx = r_chk_idx;
        n_count   = r_count;
        n_break   = r_break;
        n_hit     = r_hit;
        n_hit_idx = r_hit_idx;
        n_hit_ent = r_hit_ent;
        rd_en     = 1'b0;
        we        = 1'b0;
        waddr     = r_hit_idx;
        wdata     = r_hit_ent;
        o_res     = '0;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_rd_idx = '0;
                    n_hit    = 1'b0;
                    if ((i_kind == KIND_ALLOC) && (i_request_size == '0)) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end

            S_SCAN: begin
                if (match) begin
                    n_hit     = 1'b1;
                    n_hit_idx = r_chk_idx;
                    n_hit_ent = ent;
                    n_state   = S_DONE;
                end else if (r_rd_idx < r_count) begin
                    // issue the next entry read
                    rd_en     = 1'b1;
                    n_chk_vld = 1'b1;
                    n_chk_idx = r_rd_idx[IDX_W-1:0];
                    n_rd_idx  = r_rd_idx + CNT_W'(1);
                end else begin
                    // last entry checked, or table empty, without a match
                    n_state = S_DONE;
                end
            end

            S_DONE: begin
                if (i_out_ready) begin
                    n_state = S_IDLE;
                    o_res.vld = 1'b1;
                    if (r_kind == KIND_ALLOC) begin
                        if (r_zero) begin
                            o_res.status = ST_REFUSED;
                        end else if (r_hit) begin
                            // reuse a free block whole
                            we           = 1'b1;
                            waddr        = r_hit_idx;
                            wdata        = r_hit_ent;
                            wdata.free   = 1'b0;
                            o_res.addr   = i_heap_base + r_hit_ent.start + HDR;
                            o_res.status = ST_REUSED;
                        end else if (fits) begin
                            // append a block at the break
                            we           = 1'b1;
                            waddr        = r_count[IDX_W-1:0];
                            wdata.start  = r_break;
                            wdata.size   = r_req;
                            wdata.free   = 1'b0;
                            n_count      = r_count + CNT_W'(1);
                            n_break      = new_end[ADDR_W-1:0];
                            o_res.addr   = i_heap_base + r_break + HDR;
                            o_res.status = ST_NEW;
                        end else begin
                            o_res.status = ST_REFUSED;
                        end
                    end else begin
                        if (r_hit && !r_hit_ent.free) begin
                            if (CNT_W'(r_hit_idx) + CNT_W'(1) == r_count) begin
                                // last block: pull the break back
                                n_count = CNT_W'(r_hit_idx);
                                n_break = r_hit_ent.start;
                            end else begin
                                we         = 1'b1;
                                waddr      = r_hit_idx;
                                wdata      = r_hit_ent;
                                wdata.free = 1'b1;
                            end
                            o_res.status = ST_RELEASED;
                        end else begin
                            o_res.status = ST_BADADDR;
                        end
                    end
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

/* hdl/first_fit_block_allocator.sv */
// top level of the first-fit block allocator: configuration registers and output register
// depends on ffba_pkg and ffba_ctrl
//
//  channel  handshake                 payload
//  in       i_in_valid / o_in_stall   i_kind, i_request_size, i_block_address
//  out      o_out_valid / i_out_stall o_payload_address, o_status
//  cfg      i_cfg_we                  i_cfg_index, i_cfg_data
//
// an item walks at most entry_count table entries (a zero-size allocate skips the walk), bounded
// by MAX_BLOCKS; a hit at entry k ends the walk
// the walk reads one table entry per cycle from the single read port
// the next item is accepted while a result still waits in the output register;
// a result blocked by a stalled output register holds the commit until it drains
// synchronous active-low reset empties the table and the break; no clearing pass
module first_fit_block_allocator (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_kind,
    input  logic [ffba_pkg::SIZE_W-1:0]   i_request_size,
    input  logic [ffba_pkg::ADDR_W-1:0]   i_block_address,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [ffba_pkg::ADDR_W-1:0]   o_payload_address,
    output logic [ffba_pkg::STATUS_W-1:0] o_status,
    input  logic                          i_cfg_we,
    input  logic [ffba_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ffba_pkg::ADDR_W-1:0]   i_cfg_data
);
    import ffba_pkg::*;

    logic [ADDR_W-1:0]   r_heap_base;
    logic [ADDR_W-1:0]   r_heap_limit;
    logic                r_out_vld;
    logic [ADDR_W-1:0]   r_out_addr;
    logic [STATUS_W-1:0] r_out_status;
    logic                out_ready;
    t_result             res;

    assign out_ready = !r_out_vld || !i_out_stall;

    ffba_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_kind         (i_kind),
        .i_request_size (i_request_size),
        .i_block_address(i_block_address),
        .i_heap_base    (r_heap_base),
        .i_heap_limit   (r_heap_limit),
        .i_out_ready    (out_ready),
        .o_res          (res)
    );

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heap_base  <= '0;
            r_heap_limit <= '1;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_HEAP_BASE:  r_heap_base  <= i_cfg_data;
                CFG_HEAP_LIMIT: r_heap_limit <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (res.vld) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    // output item
    always_ff @(posedge i_clk) begin
        if (res.vld) begin
            r_out_addr   <= res.addr;
            r_out_status <= res.status;
        end
    end

    assign o_out_valid       = r_out_vld;
    assign o_payload_address = r_out_addr;
    assign o_status          = r_out_status;

endmodule
